@@ sv/sha1_stream_hasher_core_assert.svh @@
// Assertion macros for the SHA-1 stream hasher.
// Expect clk and rst_n in the scope where a macro is used.
`ifndef SHA1_STREAM_HASHER_CORE_ASSERT_SVH
`define SHA1_STREAM_HASHER_CORE_ASSERT_SVH

// Same-cycle implication.
`define SHA1SH_AST_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SHA1SH_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/sha1sh_pkg.sv @@
// Shared types and constants for the SHA-1 stream hasher.
// No dependencies.
package sha1sh_pkg;

  localparam int unsigned WORDS = 5;
  localparam int unsigned SCHED_DEPTH = 16;

  localparam logic [31:0] IV [WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [5:0] LEN_POS = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [2:0] LAST_WORD = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       byte_wr;
    logic [7:0] byte_val;
    logic       push;
    logic       shift;
    logic       init_work;
    logic       round_en;
    logic [6:0] round;
    logic       add_chain;
    logic       load_iv;
    logic [2:0] out_idx;
  } ctl_t;

endpackage

@@ sv/sha1sh_sched.sv @@
// Byte packing and 16-word message schedule shift line.
// Depends on sha1sh_pkg.
module sha1sh_sched (
  input  logic               clk,
  input  sha1sh_pkg::ctl_t   ctl,
  output logic [31:0]        w0
);
  import sha1sh_pkg::*;

  logic [23:0] part_r;
  logic [23:0] part_nxt;
  logic [31:0] sreg_r [SCHED_DEPTH];
  logic [31:0] sreg_nxt [SCHED_DEPTH];
  logic [31:0] mix;
  logic [31:0] new_w;
  logic        advance;

  assign mix = sreg_r[13] ^ sreg_r[8] ^ sreg_r[2] ^ sreg_r[0];
  assign new_w = ctl.push ? {part_r, ctl.byte_val} : {mix[30:0], mix[31]};
  assign advance = ctl.push | ctl.shift;
  assign w0 = sreg_r[0];

  always_comb begin
    part_nxt = ctl.byte_wr ? {part_r[15:0], ctl.byte_val} : part_r;
    for (int i = 0; i < SCHED_DEPTH; i++) begin
      if (!advance) begin
        sreg_nxt[i] = sreg_r[i];
      end else if (i == SCHED_DEPTH - 1) begin
        sreg_nxt[i] = new_w;
      end else begin
        sreg_nxt[i] = sreg_r[i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    part_r <= part_nxt;
    for (int i = 0; i < SCHED_DEPTH; i++) begin
      sreg_r[i] <= sreg_nxt[i];
    end
  end

endmodule

@@ sv/sha1sh_round.sv @@
// Shared SHA-1 round unit, working registers and chaining value.
// Depends on sha1sh_pkg.
module sha1sh_round (
  input  logic               clk,
  input  logic               rst_n,
  input  sha1sh_pkg::ctl_t   ctl,
  input  logic [31:0]        w0,
  output logic [31:0]        digest_word
);
  import sha1sh_pkg::*;

  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [31:0] chain_r [WORDS];
  logic [31:0] chain_nxt [WORDS];
  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] t;

  always_comb begin
    if (ctl.round < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r);
      k = K0;
    end else if (ctl.round < 7'd40) begin
      f = b_r ^ c_r ^ d_r;
      k = K1;
    end else if (ctl.round < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k = K2;
    end else begin
      f = b_r ^ c_r ^ d_r;
      k = K3;
    end
  end

  assign t = {a_r[26:0], a_r[31:27]} + f + e_r + k + w0;

  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    c_nxt = c_r;
    d_nxt = d_r;
    e_nxt = e_r;
    if (ctl.init_work) begin
      a_nxt = chain_r[0];
      b_nxt = chain_r[1];
      c_nxt = chain_r[2];
      d_nxt = chain_r[3];
      e_nxt = chain_r[4];
    end else if (ctl.round_en) begin
      a_nxt = t;
      b_nxt = a_r;
      c_nxt = {b_r[1:0], b_r[31:2]};
      d_nxt = c_r;
      e_nxt = d_r;
    end
  end

  always_comb begin
    for (int i = 0; i < WORDS; i++) begin
      chain_nxt[i] = chain_r[i];
    end
    if (ctl.load_iv) begin
      for (int i = 0; i < WORDS; i++) begin
        chain_nxt[i] = IV[i];
      end
    end else if (ctl.add_chain) begin
      chain_nxt[0] = chain_r[0] + a_r;
      chain_nxt[1] = chain_r[1] + b_r;
      chain_nxt[2] = chain_r[2] + c_r;
      chain_nxt[3] = chain_r[3] + d_r;
      chain_nxt[4] = chain_r[4] + e_r;
    end
  end

  always_comb begin
    case (ctl.out_idx)
      3'd0:    digest_word = chain_r[0];
      3'd1:    digest_word = chain_r[1];
      3'd2:    digest_word = chain_r[2];
      3'd3:    digest_word = chain_r[3];
      3'd4:    digest_word = chain_r[4];
      default: digest_word = chain_r[0];
    endcase
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    c_r <= c_nxt;
    d_r <= d_nxt;
    e_r <= e_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WORDS; i++) begin
        chain_r[i] <= IV[i];
      end
    end else begin
      for (int i = 0; i < WORDS; i++) begin
        chain_r[i] <= chain_nxt[i];
      end
    end
  end

endmodule

@@ sv/sha1sh_ctrl.sv @@
// Sequencer: byte intake, padding, round count and digest readout.
// Depends on sha1sh_pkg.
module sha1sh_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_byte_valid,
  input  logic               in_end_of_message,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_word_number,
  output logic               out_final_word,
  output sha1sh_pkg::ctl_t   ctl
);
  import sha1sh_pkg::*;

  state_t      state_r, state_nxt;
  logic [63:0] msg_bits_r, msg_bits_nxt;
  logic [63:0] len_r, len_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [6:0]  round_r, round_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        fin_r, fin_nxt;
  logic        pad_first_r, pad_first_nxt;
  logic        len_phase_r, len_phase_nxt;
  logic        len_now;

  assign len_now = len_phase_r | (!pad_first_r && pos_r == LEN_POS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      msg_bits_r  <= '0;
      pos_r       <= '0;
      round_r     <= '0;
      idx_r       <= '0;
      fin_r       <= 1'b0;
      pad_first_r <= 1'b0;
      len_phase_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      msg_bits_r  <= msg_bits_nxt;
      pos_r       <= pos_nxt;
      round_r     <= round_nxt;
      idx_r       <= idx_nxt;
      fin_r       <= fin_nxt;
      pad_first_r <= pad_first_nxt;
      len_phase_r <= len_phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    msg_bits_nxt  = msg_bits_r;
    len_nxt       = len_r;
    round_nxt     = round_r;
    idx_nxt       = idx_r;
    fin_nxt       = fin_r;
    pad_first_nxt = pad_first_r;
    len_phase_nxt = len_phase_r;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    ctl           = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          fin_nxt       = in_end_of_message;
          pad_first_nxt = in_end_of_message;
          if (in_byte_valid) begin
            ctl.byte_wr  = 1'b1;
            ctl.byte_val = in_data_byte;
            msg_bits_nxt = msg_bits_r + 64'd8;
          end
          if (in_byte_valid && pos_r == LAST_POS) begin
            ctl.init_work = 1'b1;
            state_nxt     = ST_ROUND;
          end else if (in_end_of_message) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        ctl.byte_wr   = 1'b1;
        pad_first_nxt = 1'b0;
        if (pad_first_r) begin
          ctl.byte_val = PAD_BYTE;
          len_nxt      = msg_bits_r;
        end else if (len_now) begin
          ctl.byte_val  = len_r[63:56];
          len_nxt       = {len_r[55:0], 8'h00};
          len_phase_nxt = 1'b1;
        end else begin
          ctl.byte_val = 8'h00;
        end
        if (pos_r == LAST_POS) begin
          ctl.init_work = 1'b1;
          state_nxt     = ST_ROUND;
        end
      end
      ST_ROUND: begin
        ctl.round_en = 1'b1;
        ctl.shift    = 1'b1;
        round_nxt    = round_r + 7'd1;
        if (round_r == LAST_ROUND) begin
          round_nxt = '0;
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        ctl.add_chain = 1'b1;
        if (!fin_r) begin
          state_nxt = ST_IDLE;
        end else if (len_phase_r) begin
          idx_nxt   = '0;
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_PAD;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (idx_r == LAST_WORD) begin
            ctl.load_iv   = 1'b1;
            msg_bits_nxt  = '0;
            idx_nxt       = '0;
            fin_nxt       = 1'b0;
            len_phase_nxt = 1'b0;
            state_nxt     = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    ctl.round   = round_r;
    ctl.out_idx = idx_r;
    ctl.push    = ctl.byte_wr && pos_r[1:0] == 2'b11;
    pos_nxt     = ctl.byte_wr ? pos_r + 6'd1 : pos_r;
  end

  assign out_word_number = idx_r;
  assign out_final_word  = idx_r == LAST_WORD;

endmodule

@@ sv/sha1_stream_hasher_core.sv @@
// SHA-1 stream hasher: one message byte per input item, digest words out.
// Usage:
//   Input channel in_valid/in_ready carries in_data_byte, in_byte_valid and
//   in_end_of_message. Byte items are taken back to back while in_ready is
//   high; every 64th byte starts a block compression (80 rounds, one per
//   cycle, in one shared round unit, plus the chaining add), during which
//   in_ready is low.
//   An item with in_end_of_message starts padding: one pad byte per cycle
//   through the same byte path up to the end of the block, then one or two
//   compressions. Five items then appear on out_valid/out_ready:
//   out_digest_word H0..H4 with out_word_number 0..4 and out_final_word on
//   H4. While the receiver stalls the current word holds and no input is
//   taken. After H4 is taken the chaining value and bit count return to
//   initial values and in_ready rises on the next cycle.
//   Reset (rst_n low, synchronous) loads the initial chaining value,
//   clears the bit count and leaves the block idle and ready.
// Depends on sha1sh_pkg, sha1sh_ctrl, sha1sh_sched, sha1sh_round and
// sha1_stream_hasher_core_assert.svh.
`include "sha1_stream_hasher_core_assert.svh"

module sha1_stream_hasher_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_number,
  output logic        out_final_word
);
  import sha1sh_pkg::*;

  ctl_t        ctl;
  logic [31:0] w0;

  sha1sh_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_byte_valid     (in_byte_valid),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_word_number   (out_word_number),
    .out_final_word    (out_final_word),
    .ctl               (ctl)
  );

  sha1sh_sched u_sched (
    .clk (clk),
    .ctl (ctl),
    .w0  (w0)
  );

  sha1sh_round u_round (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .w0          (w0),
    .digest_word (out_digest_word)
  );

  `SHA1SH_AST_NOW(a_excl, in_ready, !out_valid, "intake open while digest pending")
  `SHA1SH_AST_NXT(a_eom_busy, in_valid && in_ready && in_end_of_message, !in_ready,
                  "intake open right after end of message")
  `SHA1SH_AST_NXT(a_back_idle, out_valid && out_ready && out_final_word, in_ready && !out_valid,
                  "not idle after last digest word")
  `SHA1SH_AST_NXT(a_word_seq, out_valid && out_ready && !out_final_word,
                  out_valid && out_word_number == $past(out_word_number) + 3'd1,
                  "digest word order broken")

endmodule

@@ tb/tb_sha1_stream_hasher_core.sv @@
// Self-checking testbench for sha1_stream_hasher_core: streams byte items,
// predicts every SHA-1 digest word and compares the words as they come out.
// Depends only on the sha1_stream_hasher_core RTL.
module tb_sha1_stream_hasher_core;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 600;
  localparam int HOLD_AFTER_ITEMS = 60;
  localparam int DRAIN_CYCLES = 300;
  localparam int MAX_REPORTS = 10;

  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  typedef enum logic [1:0] {
    RX_FREE,
    RX_HALF,
    RX_SLOW
  } rx_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_on;
    logic       msg_end;
  } byte_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_rec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_byte_valid = 1'b0;
  logic        in_end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_number;
  logic        out_final_word;

  byte_item_t  pending_q[$];
  digest_rec_t digest_q[$];

  logic [31:0] hash_state [5];
  logic [7:0]  msg_buf [64];
  logic [63:0] bit_len;

  int items_taken = 0;
  int real_items = 0;
  int mismatches = 0;
  int cycle_cnt = 0;
  int gap_left = 0;
  int burst_left = 1;
  int hold_left = 0;
  logic hold_done = 1'b0;
  int rx_left = 0;
  rx_mode_t rx_mode = RX_FREE;

  sha1_stream_hasher_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_byte_valid    (in_byte_valid),
    .in_end_of_message(in_end_of_message),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_digest_word  (out_digest_word),
    .out_word_number  (out_word_number),
    .out_final_word   (out_final_word)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void restart_hash();
    int i;
    for (i = 0; i < 5; i++) hash_state[i] = H_INIT[i];
    bit_len = 64'd0;
  endfunction

  function automatic void fold_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t, x;
    int i;
    for (i = 0; i < 16; i++)
      w[i] = {msg_buf[4*i], msg_buf[4*i+1], msg_buf[4*i+2], msg_buf[4*i+3]};
    for (i = 16; i < 80; i++) begin
      x = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
      w[i] = {x[30:0], x[31]};
    end
    a = hash_state[0];
    b = hash_state[1];
    c = hash_state[2];
    d = hash_state[3];
    e = hash_state[4];
    for (i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5A827999;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ED9EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d;
        k = 32'hCA62C1D6;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[i];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    hash_state[0] += a;
    hash_state[1] += b;
    hash_state[2] += c;
    hash_state[3] += d;
    hash_state[4] += e;
  endfunction

  function automatic void absorb_item(logic [7:0] data, logic byte_on, logic msg_end);
    int pos;
    int i;
    if (byte_on) begin
      pos = int'(bit_len[8:3]);
      msg_buf[pos] = data;
      bit_len += 64'd8;
      if (pos == 63) fold_block();
    end
    if (msg_end) begin
      pos = int'(bit_len[8:3]);
      msg_buf[pos] = 8'h80;
      for (i = pos + 1; i < 64; i++) msg_buf[i] = 8'h00;
      if (pos >= 56) begin
        fold_block();
        for (i = 0; i < 56; i++) msg_buf[i] = 8'h00;
      end
      for (i = 0; i < 8; i++) msg_buf[56+i] = bit_len[63-8*i -: 8];
      fold_block();
      for (i = 0; i < 5; i++)
        digest_q.push_back('{word: hash_state[i], idx: 3'(i), last: (i == 4)});
      restart_hash();
    end
  endfunction

  task automatic add_item(logic [7:0] data, logic byte_on, logic msg_end);
    pending_q.push_back('{data: data, byte_on: byte_on, msg_end: msg_end});
    if (byte_on || msg_end) real_items++;
  endtask

  task automatic add_msg(int len);
    logic end_on_byte;
    int i;
    end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) add_item(8'($urandom), 1'b0, 1'b0);
      add_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
    end
    if (!end_on_byte) add_item(8'($urandom), 1'b0, 1'b1);
  endtask

  always @(posedge clk) begin : drv
    byte_item_t nxt;
    logic give;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        absorb_item(in_data_byte, in_byte_valid, in_end_of_message);
        items_taken <= items_taken + 1;
      end
      if (!in_valid || in_ready) begin
        give = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q.size() > 0) begin
          nxt = pending_q.pop_front();
          give = 1'b1;
          in_data_byte <= nxt.data;
          in_byte_valid <= nxt.byte_on;
          in_end_of_message <= nxt.msg_end;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
        in_valid <= give;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_done && items_taken >= HOLD_AFTER_ITEMS) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin : rcv
    logic rdy;
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_left = $urandom_range(4, 40);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_FREE: rdy = 1'b1;
      RX_HALF: rdy = ($urandom_range(0, 1) == 1);
      default: rdy = ($urandom_range(0, 3) == 0);
    endcase
    out_ready <= rdy && (hold_left == 0);
  end

  always @(posedge clk) begin : mon
    digest_rec_t want;
    if (rst_n && out_valid && out_ready) begin
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected digest word %08h num %0d last %0b",
                   out_digest_word, out_word_number, out_final_word);
      end else begin
        want = digest_q.pop_front();
        if (out_digest_word !== want.word || out_word_number !== want.idx ||
            out_final_word !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: exp %08h num %0d last %0b, got %08h num %0d last %0b",
                     want.word, want.idx, want.last,
                     out_digest_word, out_word_number, out_final_word);
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb_sha1_stream_hasher_core failed");
    $finish;
  end

  initial begin : stim
    int len;
    int sel;
    restart_hash();

    // empty messages, back to back and after an idle item
    add_item(8'hA5, 1'b0, 1'b1);
    add_item(8'h5A, 1'b0, 1'b1);
    add_item(8'hFF, 1'b0, 1'b0);
    add_item(8'h00, 1'b0, 1'b1);
    // byte extremes, end flag on the last byte
    add_item(8'h00, 1'b1, 1'b0);
    add_item(8'hFF, 1'b1, 1'b1);
    add_item(8'hFF, 1'b1, 1'b1);
    // "abc" closed by a separate empty end item
    add_item(8'h61, 1'b1, 1'b0);
    add_item(8'h62, 1'b1, 1'b0);
    add_item(8'h63, 1'b1, 1'b0);
    add_item(8'hC3, 1'b0, 1'b1);
    add_item(8'h80, 1'b1, 1'b0);
    add_item(8'h00, 1'b0, 1'b0);
    add_item(8'h00, 1'b1, 1'b0);
    add_item(8'h3C, 1'b0, 1'b1);

    // padding fits, padding spills into a second block, exact block
    add_msg(55);
    add_msg(56);
    add_msg(64);
    while (real_items < 310) begin
      sel = $urandom_range(0, 19);
      if (sel < 14) len = $urandom_range(0, 12);
      else if (sel < 19) len = $urandom_range(50, 66);
      else len = $urandom_range(118, 121);
      add_msg(len);
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (pending_q.size() != 0 || in_valid || digest_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("tb_sha1_stream_hasher_core passed");
    end else begin
      $display("tb_sha1_stream_hasher_core failed");
    end
    $finish;
  end

endmodule
